// ===== hw/rtl/gcce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Grid cell code encoder package
// Field widths, register layout, error codes and the constant tables of the
// mixed-radix grid code.
// ----------------------------------------------------------------------------
package gcce_pkg;

  // Field widths of the input and result transactions.
  localparam int COORD_W  = 33;
  localparam int LEVEL_W  = 5;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 4;
  localparam int ERR_W    = 2;

  // Configuration register widths and the bus layout.
  localparam int ORIGIN_W = 34;
  localparam int SCALE_W  = 36;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 5;

  // Arithmetic widths: a positive offset fits 34 bits, the cell index 26 bits.
  localparam int DIFF_W   = 34;
  localparam int INDEX_W  = 26;
  localparam int PROD_W   = DIFF_W + SCALE_W;
  localparam int FRAC_SH  = 40;
  localparam int DIGIT_W  = 3;

  localparam int GRID_DIGITS = 15;
  localparam int MAX_LEVEL   = 15;

  localparam logic [INDEX_W-1:0] INDEX_LIMIT = 26'd49999999;

  // Accepted coordinate range, degrees with 24 fraction bits.
  localparam logic signed [COORD_W:0] LON_BOUND = 34'sd3019898880;
  localparam logic signed [COORD_W:0] LAT_BOUND = 34'sd1509949440;

  // Register reset values.
  localparam logic signed [ORIGIN_W-1:0] LON_ORIGIN_RST = -34'sd3623878656;
  localparam logic signed [ORIGIN_W-1:0] LAT_ORIGIN_RST = -34'sd2063597568;
  localparam logic [SCALE_W-1:0]         SCALE_RST      = 36'd7298018963;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_LON   = 2'd1,
    ERR_LAT   = 2'd2,
    ERR_LEVEL = 2'd3
  } err_code_t;

  typedef enum logic [1:0] {
    REG_LON_ORIGIN = 2'd0,
    REG_LAT_ORIGIN = 2'd1,
    REG_LON_SCALE  = 2'd2,
    REG_LAT_SCALE  = 2'd3
  } reg_idx_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic signed [ORIGIN_W-1:0] lon_origin;
    logic signed [ORIGIN_W-1:0] lat_origin;
    logic [SCALE_W-1:0]         lon_scale;
    logic [SCALE_W-1:0]         lat_scale;
  } cfg_t;

  // Place value of digit pos: the product of all radices after it.
  function automatic logic [INDEX_W-1:0] grid_weight(input logic [POS_W-1:0] pos);
    logic [INDEX_W-1:0] w;
    case (pos)
      4'd0:    w = 26'd10000000;
      4'd1:    w = 26'd5000000;
      4'd2:    w = 26'd1000000;
      4'd3:    w = 26'd500000;
      4'd4:    w = 26'd100000;
      4'd5:    w = 26'd50000;
      4'd6:    w = 26'd10000;
      4'd7:    w = 26'd5000;
      4'd8:    w = 26'd1000;
      4'd9:    w = 26'd500;
      4'd10:   w = 26'd100;
      4'd11:   w = 26'd50;
      4'd12:   w = 26'd10;
      4'd13:   w = 26'd5;
      4'd14:   w = 26'd1;
      default: w = 26'd1;
    endcase
    return w;
  endfunction

  // The 25-letter code alphabet, row-major by latitude digit then longitude digit.
  function automatic logic [CHAR_W-1:0] code_letter(input logic [4:0] sel);
    logic [CHAR_W-1:0] c;
    case (sel)
      5'd0:    c = 8'h32;
      5'd1:    c = 8'h33;
      5'd2:    c = 8'h34;
      5'd3:    c = 8'h35;
      5'd4:    c = 8'h36;
      5'd5:    c = 8'h37;
      5'd6:    c = 8'h38;
      5'd7:    c = 8'h39;
      5'd8:    c = 8'h43;
      5'd9:    c = 8'h45;
      5'd10:   c = 8'h46;
      5'd11:   c = 8'h47;
      5'd12:   c = 8'h48;
      5'd13:   c = 8'h4A;
      5'd14:   c = 8'h4C;
      5'd15:   c = 8'h4D;
      5'd16:   c = 8'h4E;
      5'd17:   c = 8'h50;
      5'd18:   c = 8'h51;
      5'd19:   c = 8'h52;
      5'd20:   c = 8'h54;
      5'd21:   c = 8'h56;
      5'd22:   c = 8'h57;
      5'd23:   c = 8'h58;
      5'd24:   c = 8'h59;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gcce_point_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Point channel
// Valid/ready channel that carries one coordinate pair and a code level.
// ----------------------------------------------------------------------------
interface gcce_point_if;
  import gcce_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] longitude;
  logic signed [COORD_W-1:0] latitude;
  logic [LEVEL_W-1:0]        level;

  modport source (output valid, output longitude, output latitude, output level,
                  input ready);
  modport sink   (input valid, input longitude, input latitude, input level,
                  output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/gcce_code_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Code channel
// Valid/ready channel that carries one code character per transaction.
// ----------------------------------------------------------------------------
interface gcce_code_if;
  import gcce_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] code_char;
  logic [POS_W-1:0]  char_position;
  logic [ERR_W-1:0]  error_code;
  logic              last;

  modport source (output valid, output code_char, output char_position,
                  output error_code, output last, input ready);
  modport sink   (input valid, input code_char, input char_position,
                  input error_code, input last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/gcce_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the grid origins and cell scales.
// ----------------------------------------------------------------------------
module gcce_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [gcce_pkg::ADDR_W-1:0] paddr,
  input  wire logic [gcce_pkg::DATA_W-1:0] pwdata,
  output logic [gcce_pkg::DATA_W-1:0]      prdata,
  output logic                           pready,
  output gcce_pkg::cfg_t                 cfg
);
  import gcce_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  // Registers sit on 8-byte boundaries.
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lon_origin <= LON_ORIGIN_RST;
      cfg.lat_origin <= LAT_ORIGIN_RST;
      cfg.lon_scale  <= SCALE_RST;
      cfg.lat_scale  <= SCALE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LON_ORIGIN: cfg.lon_origin <= pwdata[ORIGIN_W-1:0];
        REG_LAT_ORIGIN: cfg.lat_origin <= pwdata[ORIGIN_W-1:0];
        REG_LON_SCALE:  cfg.lon_scale  <= pwdata[SCALE_W-1:0];
        REG_LAT_SCALE:  cfg.lat_scale  <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data is the raw register bits, zero-extended.
  always_comb begin
    case (idx)
      REG_LON_ORIGIN: prdata = {{(DATA_W-ORIGIN_W){1'b0}}, cfg.lon_origin};
      REG_LAT_ORIGIN: prdata = {{(DATA_W-ORIGIN_W){1'b0}}, cfg.lat_origin};
      REG_LON_SCALE:  prdata = {{(DATA_W-SCALE_W){1'b0}}, cfg.lon_scale};
      REG_LAT_SCALE:  prdata = {{(DATA_W-SCALE_W){1'b0}}, cfg.lat_scale};
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gcce_index_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Cell index unit
// Computes floor((coord - origin) * scale / 2^40) for both coordinates with
// one shared 17x18 multiplier, four partial products per coordinate.
// ----------------------------------------------------------------------------
module gcce_index_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [gcce_pkg::COORD_W-1:0] lon,
  input  wire logic signed [gcce_pkg::COORD_W-1:0] lat,
  input  wire gcce_pkg::cfg_t                    cfg,
  output logic [gcce_pkg::INDEX_W-1:0]           x_index,
  output logic [gcce_pkg::INDEX_W-1:0]           y_index,
  output logic                                   done
);
  import gcce_pkg::*;

  localparam int D_LO_W = DIFF_W / 2;
  localparam int D_HI_W = DIFF_W - D_LO_W;
  localparam int S_LO_W = SCALE_W / 2;
  localparam int S_HI_W = SCALE_W - S_LO_W;
  localparam int A_W    = (D_LO_W > D_HI_W) ? D_LO_W : D_HI_W;
  localparam int B_W    = (S_LO_W > S_HI_W) ? S_LO_W : S_HI_W;
  localparam int P_W    = A_W + B_W;
  localparam int Q_W    = PROD_W - FRAC_SH;

  logic [DIFF_W:0]   lon_diff, lat_diff;
  logic [DIFF_W-1:0] d_lon, d_lat, d_sel;
  logic [SCALE_W-1:0] s_sel;
  logic [A_W-1:0]    mul_a;
  logic [B_W-1:0]    mul_b;
  logic              issue;
  logic [2:0]        cnt;
  logic [P_W-1:0]    prod;
  logic [2:0]        prod_k;
  logic              prod_v;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] prod_sh, sum;
  logic [Q_W-1:0]    quot;
  logic [INDEX_W-1:0] idx_sat;

  // Offsets from the grid origin; anything west or south of it counts as zero.
  assign lon_diff = {{(DIFF_W+1-COORD_W){lon[COORD_W-1]}}, lon}
                  - {cfg.lon_origin[ORIGIN_W-1], cfg.lon_origin};
  assign lat_diff = {{(DIFF_W+1-COORD_W){lat[COORD_W-1]}}, lat}
                  - {cfg.lat_origin[ORIGIN_W-1], cfg.lat_origin};

  // Operand selection: cnt[2] picks the coordinate, cnt[1] the offset half,
  // cnt[0] the scale half.
  assign d_sel = cnt[2] ? d_lat : d_lon;
  assign s_sel = cnt[2] ? cfg.lat_scale : cfg.lon_scale;
  assign mul_a = cnt[1] ? A_W'(d_sel[DIFF_W-1:D_LO_W]) : A_W'(d_sel[D_LO_W-1:0]);
  assign mul_b = cnt[0] ? B_W'(s_sel[SCALE_W-1:S_LO_W]) : B_W'(s_sel[S_LO_W-1:0]);

  // Align the registered partial product and add it to the running sum.
  always_comb begin
    prod_sh = PROD_W'(prod);
    case (prod_k[1:0])
      2'd0:    prod_sh = PROD_W'(prod);
      2'd1:    prod_sh = PROD_W'(prod) << S_LO_W;
      2'd2:    prod_sh = PROD_W'(prod) << D_LO_W;
      2'd3:    prod_sh = PROD_W'(prod) << (D_LO_W + S_LO_W);
      default: prod_sh = PROD_W'(prod);
    endcase
    sum     = ((prod_k[1:0] == 2'd0) ? '0 : acc) + prod_sh;
    quot    = sum[PROD_W-1:FRAC_SH];
    idx_sat = (quot > Q_W'(INDEX_LIMIT)) ? INDEX_LIMIT : quot[INDEX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue  <= 1'b0;
      cnt    <= '0;
      prod_v <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        issue <= 1'b1;
        cnt   <= '0;
        d_lon <= (!lon_diff[DIFF_W] && (|lon_diff[DIFF_W-1:0])) ? lon_diff[DIFF_W-1:0] : '0;
        d_lat <= (!lat_diff[DIFF_W] && (|lat_diff[DIFF_W-1:0])) ? lat_diff[DIFF_W-1:0] : '0;
      end else if (issue) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          issue <= 1'b0;
        end
      end

      // Multiply stage.
      prod_v <= issue && !start;
      prod   <= mul_a * mul_b;
      prod_k <= cnt;

      // Accumulate stage; the fourth product of a coordinate closes its index.
      if (prod_v) begin
        acc <= sum;
        if (prod_k[1:0] == 2'd3) begin
          if (prod_k[2]) begin
            y_index <= idx_sat;
            done    <= 1'b1;
          end else begin
            x_index <= idx_sat;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gcce_digit_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Digit lane
// Splits a cell index into mixed-radix digits, most significant first, one
// digit per step by comparing the remainder against the digit's place value.
// ----------------------------------------------------------------------------
module gcce_digit_lane (
  input  wire logic                          clk,
  input  wire logic                          load,
  input  wire logic [gcce_pkg::INDEX_W-1:0]  value,
  input  wire logic                          step,
  input  wire logic [gcce_pkg::POS_W-1:0]    pos,
  output logic [gcce_pkg::DIGIT_W-1:0]       digit
);
  import gcce_pkg::*;

  logic [INDEX_W-1:0] rem;
  logic [INDEX_W-1:0] w1, w2, w3, w4, sub;

  // Multiples of the place value; the remainder always stays below radix * w.
  assign w1 = grid_weight(pos);
  assign w2 = w1 << 1;
  assign w3 = w1 + w2;
  assign w4 = w1 << 2;

  always_comb begin
    // Even positions have radix 5, odd positions radix 2.
    if (!pos[0]) begin
      if (rem >= w4)      digit = 3'd4;
      else if (rem >= w3) digit = 3'd3;
      else if (rem >= w2) digit = 3'd2;
      else if (rem >= w1) digit = 3'd1;
      else                digit = 3'd0;
    end else begin
      digit = (rem >= w1) ? 3'd1 : 3'd0;
    end
    case (digit)
      3'd1:    sub = w1;
      3'd2:    sub = w2;
      3'd3:    sub = w3;
      3'd4:    sub = w4;
      default: sub = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= value;
    end else if (step) begin
      rem <= rem - sub;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/grid_cell_code_encoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Grid cell code encoder
// Turns a longitude/latitude point into a hierarchical grid code of up to
// fifteen characters, one character per result transaction.
// ----------------------------------------------------------------------------
// An item is accepted, the origin offsets are formed, the partial products pass
// through the shared 17x18 multiplier (four partial products per coordinate)
// and are accumulated, and the indices are handed to the digit lanes; then
// one code character per cycle while the result channel takes them. An
// item that fails a range check skips the index unit and gives a single result.
// The point channel is ready only between items; the next item may be taken
// while the last character still waits in the output register. No clearing
// pass is needed after reset.
module grid_cell_code_encoder_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  gcce_point_if.sink                       point,
  gcce_code_if.source                      code,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gcce_pkg::ADDR_W-1:0] paddr,
  input  wire logic [gcce_pkg::DATA_W-1:0] pwdata,
  output logic [gcce_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);
  import gcce_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ERROR,
    S_INDEX,
    S_EMIT
  } state_t;

  state_t                state;
  cfg_t                  cfg;
  logic signed [COORD_W-1:0] lon_q, lat_q;
  logic [LEVEL_W-1:0]    level_q;
  err_code_t             err_q, err_in;
  logic [POS_W-1:0]      pos;
  logic                  start;
  logic                  idx_done;
  logic [INDEX_W-1:0]    x_index, y_index;
  logic [DIGIT_W-1:0]    dx, dy;
  logic                  accept, out_free, lane_load, lane_step, pos_last;
  logic signed [COORD_W:0] lon_ext, lat_ext;
  logic [4:0]            sel;

  gcce_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gcce_index_unit u_index (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .lon     (lon_q),
    .lat     (lat_q),
    .cfg     (cfg),
    .x_index (x_index),
    .y_index (y_index),
    .done    (idx_done)
  );

  gcce_digit_lane u_lane_x (
    .clk   (clk),
    .load  (lane_load),
    .value (x_index),
    .step  (lane_step),
    .pos   (pos),
    .digit (dx)
  );

  gcce_digit_lane u_lane_y (
    .clk   (clk),
    .load  (lane_load),
    .value (y_index),
    .step  (lane_step),
    .pos   (pos),
    .digit (dy)
  );

  // Range checks, in order longitude, latitude, level.
  assign lon_ext = {point.longitude[COORD_W-1], point.longitude};
  assign lat_ext = {point.latitude[COORD_W-1], point.latitude};

  always_comb begin
    if (lon_ext < -LON_BOUND || lon_ext > LON_BOUND) begin
      err_in = ERR_LON;
    end else if (lat_ext < -LAT_BOUND || lat_ext > LAT_BOUND) begin
      err_in = ERR_LAT;
    end else if (point.level == '0 || point.level > LEVEL_W'(MAX_LEVEL)) begin
      err_in = ERR_LEVEL;
    end else begin
      err_in = ERR_NONE;
    end
  end

  // Handshake and sequencing strobes.
  assign point.ready = (state == S_IDLE);
  assign accept      = point.valid && point.ready;
  assign out_free    = !code.valid || code.ready;
  assign lane_load   = (state == S_INDEX) && idx_done;
  assign lane_step   = (state == S_EMIT) && out_free;
  assign pos_last    = ({1'b0, pos} == (level_q - LEVEL_W'(1)));
  assign sel         = 5'({dy, 2'b00}) + 5'(dy) + 5'(dx);

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      start      <= 1'b0;
      code.valid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (code.ready) begin
        code.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            lon_q   <= point.longitude;
            lat_q   <= point.latitude;
            level_q <= point.level;
            err_q   <= err_in;
            if (err_in != ERR_NONE) begin
              state <= S_ERROR;
            end else begin
              start <= 1'b1;
              state <= S_INDEX;
            end
          end
        end
        S_ERROR: begin
          if (out_free) begin
            code.valid         <= 1'b1;
            code.code_char     <= '0;
            code.char_position <= '0;
            code.error_code    <= err_q;
            code.last          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        S_INDEX: begin
          if (idx_done) begin
            pos   <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            code.valid         <= 1'b1;
            code.code_char     <= code_letter(sel);
            code.char_position <= pos;
            code.error_code    <= ERR_NONE;
            code.last          <= pos_last;
            pos                <= pos + POS_W'(1);
            if (pos_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
